// ===== hdl/udfu_pkg.sv =====
`default_nettype none

package udfu_pkg;

    // Request kinds, as carried on s_tuser
    typedef enum logic [2:0] {
        KIND_DNLOAD    = 3'd0,
        KIND_UPLOAD    = 3'd1,
        KIND_GETSTATUS = 3'd2,
        KIND_CLRSTATUS = 3'd3,
        KIND_GETSTATE  = 3'd4,
        KIND_ABORT     = 3'd5,
        KIND_PROG_DONE = 3'd6,
        KIND_OTHER     = 3'd7
    } kind_t;

    // DFU state, one-hot
    typedef enum logic [5:0] {
        ST_IDLE      = 6'b000001,
        ST_DN_SYNC   = 6'b000010,
        ST_DN_IDLE   = 6'b000100,
        ST_MAN_SYNC  = 6'b001000,
        ST_MANIFEST  = 6'b010000,
        ST_ERROR     = 6'b100000
    } dfu_state_t;

    // Reported state codes
    localparam logic [2:0] CODE_IDLE     = 3'd0;
    localparam logic [2:0] CODE_DN_SYNC  = 3'd1;
    localparam logic [2:0] CODE_DN_IDLE  = 3'd2;
    localparam logic [2:0] CODE_MAN_SYNC = 3'd3;
    localparam logic [2:0] CODE_MANIFEST = 3'd4;
    localparam logic [2:0] CODE_ERROR    = 3'd5;

    localparam logic [12:0] STATUS_REPLY_LEN = 13'd6;
    localparam logic [12:0] STATE_REPLY_LEN  = 13'd1;
    localparam logic [12:0] MAX_XFER_RESET   = 13'd1024;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] block_number;
        logic [12:0] length;
        logic        program_ok;
    } item_t;

    typedef struct packed {
        logic        accepted;
        logic [12:0] reply_length;
        logic [2:0]  reply_state;
        logic        reply_status;
        logic        program_request;
        logic [31:0] program_address;
        logic [12:0] program_length;
    } result_t;

    function automatic logic [2:0] state_code(input dfu_state_t st);
        logic [2:0] code;
        unique case (st)
            ST_IDLE:     code = CODE_IDLE;
            ST_DN_SYNC:  code = CODE_DN_SYNC;
            ST_DN_IDLE:  code = CODE_DN_IDLE;
            ST_MAN_SYNC: code = CODE_MAN_SYNC;
            ST_MANIFEST: code = CODE_MANIFEST;
            ST_ERROR:    code = CODE_ERROR;
            default:     code = CODE_IDLE;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/udfu_in_reg.sv =====
`default_nettype none

module udfu_in_reg (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire udfu_pkg::item_t s_item,
    input  wire logic           advance,
    output logic                item_valid,
    output udfu_pkg::item_t     item
);

    logic            valid_reg;
    udfu_pkg::item_t item_reg;

    // Free slot, or the held beat leaves this cycle
    assign s_tready   = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= s_item;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/udfu_core.sv =====
`default_nettype none

module udfu_core (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            cfg_wr_en,
    input  wire logic [12:0]     cfg_wr_data,
    input  wire udfu_pkg::item_t item,
    input  wire logic            fire,
    output udfu_pkg::result_t    result
);

    udfu_pkg::dfu_state_t state_reg, state_next;
    logic        status_reg, status_next;
    logic [15:0] exp_block_reg, exp_block_next;
    logic [31:0] wr_addr_reg, wr_addr_next;
    logic [12:0] blk_len_reg, blk_len_next;
    logic [12:0] max_xfer_reg;

    always_comb begin
        state_next     = state_reg;
        status_next    = status_reg;
        exp_block_next = exp_block_reg;
        wr_addr_next   = wr_addr_reg;
        blk_len_next   = blk_len_reg;

        result.accepted        = 1'b0;
        result.reply_length    = '0;
        result.reply_state     = udfu_pkg::state_code(state_reg);
        result.reply_status    = status_reg;
        result.program_request = 1'b0;
        result.program_address = '0;
        result.program_length  = '0;

        unique case (item.kind)
            udfu_pkg::KIND_DNLOAD: begin
                if (item.block_number == exp_block_reg) begin
                    result.accepted     = 1'b1;
                    result.reply_length = max_xfer_reg;
                    blk_len_next        = item.length;
                    state_next = (item.length != '0) ? udfu_pkg::ST_DN_SYNC
                                                     : udfu_pkg::ST_MAN_SYNC;
                end
            end
            udfu_pkg::KIND_GETSTATUS: begin
                result.accepted     = 1'b1;
                result.reply_length = udfu_pkg::STATUS_REPLY_LEN;
                if (state_reg == udfu_pkg::ST_DN_SYNC) begin
                    // asks again on every poll while the state stays download-sync
                    result.program_request = 1'b1;
                    result.program_address = wr_addr_reg;
                    result.program_length  = blk_len_reg;
                end else if (state_reg == udfu_pkg::ST_MAN_SYNC) begin
                    state_next = udfu_pkg::ST_MANIFEST;
                end
            end
            udfu_pkg::KIND_CLRSTATUS: begin
                result.accepted = 1'b1;
                status_next     = 1'b0;
                state_next      = udfu_pkg::ST_IDLE;
            end
            udfu_pkg::KIND_GETSTATE: begin
                result.accepted     = 1'b1;
                result.reply_length = udfu_pkg::STATE_REPLY_LEN;
            end
            udfu_pkg::KIND_ABORT: begin
                result.accepted = 1'b1;
                state_next      = udfu_pkg::ST_IDLE;
            end
            udfu_pkg::KIND_PROG_DONE: begin
                result.accepted = 1'b1;
                if (item.program_ok) begin
                    wr_addr_next   = wr_addr_reg + {19'd0, blk_len_reg};
                    exp_block_next = exp_block_reg + 16'd1;
                    state_next     = udfu_pkg::ST_DN_IDLE;
                    status_next    = 1'b0;
                end else begin
                    state_next  = udfu_pkg::ST_ERROR;
                    status_next = 1'b1;
                end
            end
            default: begin
                // upload and unknown requests stall
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= udfu_pkg::ST_IDLE;
            status_reg    <= 1'b0;
            exp_block_reg <= '0;
            wr_addr_reg   <= '0;
            blk_len_reg   <= '0;
        end else if (fire) begin
            state_reg     <= state_next;
            status_reg    <= status_next;
            exp_block_reg <= exp_block_next;
            wr_addr_reg   <= wr_addr_next;
            blk_len_reg   <= blk_len_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_xfer_reg <= udfu_pkg::MAX_XFER_RESET;
        end else if (cfg_wr_en) begin
            max_xfer_reg <= cfg_wr_data;
        end
    end

    a_prog_only_in_sync: assert property (@(posedge aclk) disable iff (!aresetn)
        result.program_request |->
            (state_reg == udfu_pkg::ST_DN_SYNC) && result.accepted)
        else $error("program request outside download-sync");

    a_stall_keeps_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && !result.accepted) |=>
            $stable(state_reg) && $stable(status_reg) && $stable(exp_block_reg)
            && $stable(wr_addr_reg) && $stable(blk_len_reg))
        else $error("stalled request changed state");

    a_prog_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        !result.program_request |->
            (result.program_address == '0) && (result.program_length == '0))
        else $error("program fields set without a request");

endmodule

`default_nettype wire

// ===== hdl/udfu_out_reg.sv =====
`default_nettype none

module udfu_out_reg (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              load,
    input  wire udfu_pkg::result_t result,
    output logic                   ready,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output udfu_pkg::result_t      m_result
);

    logic              valid_reg;
    udfu_pkg::result_t result_reg;

    assign ready    = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_result = result_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ready) begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/usb_dfu_download_state_machine.sv =====
// USB DFU download sequencer, device side.
//
// s_ channel: one beat per class request or programming-done event. The
// request kind rides on s_tuser; s_tdata carries the DNLOAD block number,
// wLength and the programming result flag.
// m_ channel: exactly one result beat per input beat, in order. m_tuser
// flags whether the request was accepted or is to be stalled; m_tdata
// holds reply length, the state and status seen before the request, and
// a program command (request flag, flash address, byte count).
// cfg_wr_en/cfg_wr_data write the download buffer size reported to an
// accepted DNLOAD; write only while the block is idle.
//
// Timing: input register, combinational state update logic, output
// register. One beat per cycle is sustained while m_tready stays high;
// the state registers update as each request moves to the output
// register, so back-to-back requests see each other's effect.
// Stalls: when m_tready is low the result is held, the input register
// fills, and s_tready drops only once both stages are full.
// Reset (aresetn low, synchronous): state idle, status ok, block number,
// address and length zero, buffer size 1024, both stages empty.
`default_nettype none

module usb_dfu_download_state_machine (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        cfg_wr_en,
    input  wire logic [12:0] cfg_wr_data,   // max_transfer_bytes

    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [15:0] block_number, [28:16] length, [29] program_ok, [31:30] zero
    input  wire logic [31:0] s_tdata,
    // [2:0] kind
    input  wire logic [2:0]  s_tuser,

    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [12:0] reply_length, [15:13] reply_state, [16] reply_status,
    // [17] program_request, [49:18] program_address,
    // [62:50] program_length, [63] zero
    output logic [63:0]      m_tdata,
    // [0] accepted
    output logic [0:0]       m_tuser
);

    udfu_pkg::item_t   s_item;
    udfu_pkg::item_t   item;
    udfu_pkg::result_t result;
    udfu_pkg::result_t m_result;
    logic              item_valid;
    logic              out_ready;
    logic              advance;

    // unpack the incoming beat
    assign s_item.kind         = udfu_pkg::kind_t'(s_tuser);
    assign s_item.block_number = s_tdata[15:0];
    assign s_item.length       = s_tdata[28:16];
    assign s_item.program_ok   = s_tdata[29];

    // a held request moves on when the result register can take it
    assign advance = item_valid && out_ready;

    udfu_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    udfu_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item        (item),
        .fire        (advance),
        .result      (result)
    );

    udfu_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance),
        .result   (result),
        .ready    (out_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_result (m_result)
    );

    // pack the result beat
    assign m_tuser[0]     = m_result.accepted;
    assign m_tdata[12:0]  = m_result.reply_length;
    assign m_tdata[15:13] = m_result.reply_state;
    assign m_tdata[16]    = m_result.reply_status;
    assign m_tdata[17]    = m_result.program_request;
    assign m_tdata[49:18] = m_result.program_address;
    assign m_tdata[62:50] = m_result.program_length;
    assign m_tdata[63]    = 1'b0;

endmodule

`default_nettype wire
